>>> rtl/core/sdfs_pkg.sv
`default_nettype none
package sdfs_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 15;
  localparam int unsigned CountWidth    = 16;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;
  typedef logic [CountWidth-1:0]    count_t;
  typedef logic [14:0]              limit_t;

  // register indexes
  localparam cfg_index_t RegVoltageMin       = 3'd0;
  localparam cfg_index_t RegVoltageMax       = 3'd1;
  localparam cfg_index_t RegSameLevelLimit   = 3'd2;
  localparam cfg_index_t RegLevelChangeWin   = 3'd3;
  localparam cfg_index_t RegInactiveLimit    = 3'd4;
  localparam cfg_index_t RegActiveHold       = 3'd5;

  // test status codes
  localparam logic [1:0] StError  = 2'd1;
  localparam logic [1:0] StDoneOk = 2'd2;

  // fault byte bits
  localparam logic [7:0] BitRamFail   = 8'h04;
  localparam logic [7:0] BitRomFail   = 8'h08;
  localparam logic [7:0] BitRfDefect  = 8'h20;

  localparam logic [7:0] SupplyInvalid = 8'hff;

  localparam logic [7:0] VoltageMinReset     = 8'd0;
  localparam logic [7:0] VoltageMaxReset     = 8'd255;
  localparam limit_t     SameLevelLimitReset = 15'd1200;
  localparam limit_t     LevelChangeWinReset = 15'd1200;
  localparam limit_t     InactiveLimitReset  = 15'd6000;
  localparam limit_t     ActiveHoldReset     = 15'd2400;

  typedef struct packed {
    limit_t same_level_limit;
    limit_t level_change_window;
    limit_t inactive_limit;
    limit_t active_hold;
  } wd_cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/sdfs_if.sv
`default_nettype none
interface sdfs_in_if;
  logic       valid;
  logic       ready;
  logic       full_mode;
  logic [7:0] supply_voltage;
  logic [7:0] noise_level;
  logic       receiver_processing;
  logic [1:0] ram_test_status;
  logic [1:0] rom_test_status;

  modport source (
    output valid, full_mode, supply_voltage, noise_level, receiver_processing,
           ram_test_status, rom_test_status,
    input  ready
  );
  modport sink (
    input  valid, full_mode, supply_voltage, noise_level, receiver_processing,
           ram_test_status, rom_test_status,
    output ready
  );
endinterface

interface sdfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] fault_reasons;
  logic       report_valid;
  logic       receiver_error;

  modport source (
    output valid, fault_reasons, report_valid, receiver_error,
    input  ready
  );
  modport sink (
    input  valid, fault_reasons, report_valid, receiver_error,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/core/sdfs_rf_watchdog.sv
`default_nettype none
module sdfs_rf_watchdog
  import sdfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       update,
  input  wire logic [7:0] noise_level,
  input  wire logic       receiver_processing,
  input  wire wd_cfg_t    cfg,
  output logic            receiver_error
);

  logic [7:0] last_noise;
  count_t     same_level_count;
  count_t     inactive_count;

  logic [7:0] last_noise_next;
  count_t     same_level_count_next;
  count_t     inactive_count_next;

  logic            same_at_limit;
  logic            same_in_window;
  logic            inact_at_limit;
  logic            inact_in_hold;
  logic [CountWidth:0] same_end;
  logic [CountWidth:0] inact_end;
  logic            noise_err;
  logic            inact_err;

  always_comb begin
    same_end = {2'b00, cfg.same_level_limit} + {2'b00, cfg.level_change_window};
    inact_end = {2'b00, cfg.inactive_limit} + {2'b00, cfg.active_hold};
    same_at_limit  = same_level_count >= {1'b0, cfg.same_level_limit};
    same_in_window = same_end > {1'b0, same_level_count};
    inact_at_limit = inactive_count >= {1'b0, cfg.inactive_limit};
    inact_in_hold  = inact_end > {1'b0, inactive_count};

    // stuck noise level
    noise_err = 1'b0;
    same_level_count_next = same_level_count;
    if (noise_level == last_noise) begin
      if (same_at_limit) noise_err = 1'b1;
      else same_level_count_next = same_level_count + 1'b1;
    end else if (same_at_limit) begin
      if (same_in_window) begin
        noise_err = 1'b1;
        same_level_count_next = '0;
      end
    end else begin
      same_level_count_next = '0;
    end
    last_noise_next = noise_level;

    // receiver inactivity, held for a while after processing resumes
    inact_err = 1'b0;
    if (receiver_processing) begin
      if (inact_at_limit && inact_in_hold) begin
        inactive_count_next = inactive_count + 1'b1;
        inact_err = 1'b1;
      end else begin
        inactive_count_next = '0;
      end
    end else if (inact_at_limit) begin
      inactive_count_next = inactive_count;
      inact_err = 1'b1;
    end else begin
      inactive_count_next = inactive_count + 1'b1;
    end

    receiver_error = noise_err | inact_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_noise       <= '0;
      same_level_count <= '0;
      inactive_count   <= '0;
    end else if (update) begin
      last_noise       <= last_noise_next;
      same_level_count <= same_level_count_next;
      inactive_count   <= inactive_count_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/self_diag_fault_supervisor.sv
`default_nettype none
// Diagnostic fault supervisor: each item is one diagnostic tick and yields
// exactly one result item. A tick acts only in full mode with a valid supply
// reading (not 255, strictly between voltage_min and voltage_max); it then
// runs the receiver watchdog and updates the fault byte, whose RAM and ROM
// bits are sticky. An item is registered on entry and its result is worked
// out from that register into the output register, so one item is taken
// every cycle while the output is not stalled; the fault byte and the
// watchdog counters are updated in the same cycle as the output register.
// The result is valid once the item has moved on into the output register.
// Configuration writes take effect at once and are meant for idle periods.
module self_diag_fault_supervisor
  import sdfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire cfg_index_t        cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data,
  sdfs_in_if.sink                in_item,
  sdfs_out_if.source             out_item
);

  logic [7:0] voltage_min;
  logic [7:0] voltage_max;
  wd_cfg_t    wd_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_min                <= VoltageMinReset;
      voltage_max                <= VoltageMaxReset;
      wd_cfg.same_level_limit    <= SameLevelLimitReset;
      wd_cfg.level_change_window <= LevelChangeWinReset;
      wd_cfg.inactive_limit      <= InactiveLimitReset;
      wd_cfg.active_hold         <= ActiveHoldReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegVoltageMin:     voltage_min                <= cfg_data[7:0];
        RegVoltageMax:     voltage_max                <= cfg_data[7:0];
        RegSameLevelLimit: wd_cfg.same_level_limit    <= cfg_data;
        RegLevelChangeWin: wd_cfg.level_change_window <= cfg_data;
        RegInactiveLimit:  wd_cfg.inactive_limit      <= cfg_data;
        RegActiveHold:     wd_cfg.active_hold         <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid;
  logic       s1_full_mode;
  logic [7:0] s1_supply;
  logic [7:0] s1_noise;
  logic       s1_processing;
  logic [1:0] s1_ram;
  logic [1:0] s1_rom;

  logic advance;
  assign advance = s1_valid && (!out_item.valid || out_item.ready);
  assign in_item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_full_mode  <= in_item.full_mode;
      s1_supply     <= in_item.supply_voltage;
      s1_noise      <= in_item.noise_level;
      s1_processing <= in_item.receiver_processing;
      s1_ram        <= in_item.ram_test_status;
      s1_rom        <= in_item.rom_test_status;
    end
  end

  logic gated_in;
  assign gated_in = s1_full_mode && (s1_supply != SupplyInvalid) &&
                    (s1_supply > voltage_min) && (s1_supply < voltage_max);

  logic rf_err;

  sdfs_rf_watchdog u_watchdog (
    .clk                 (clk),
    .rst                 (rst),
    .update              (advance && gated_in),
    .noise_level         (s1_noise),
    .receiver_processing (s1_processing),
    .cfg                 (wd_cfg),
    .receiver_error      (rf_err)
  );

  logic [7:0] fault_byte;
  logic [7:0] fault_byte_next;
  logic       report_next;

  always_comb begin
    fault_byte_next = fault_byte;
    report_next     = 1'b0;
    if (gated_in) begin
      if (s1_ram == StError) fault_byte_next = fault_byte_next | BitRamFail;
      if (s1_rom == StError) fault_byte_next = fault_byte_next | BitRomFail;
      if (rf_err) fault_byte_next = fault_byte_next | BitRfDefect;
      else        fault_byte_next = fault_byte_next & ~BitRfDefect;
      if (fault_byte_next != 8'h00) begin
        report_next = fault_byte_next != fault_byte;
      end else begin
        // all clear only once both memory tests have passed
        report_next = !rf_err && (s1_ram == StDoneOk) && (s1_rom == StDoneOk);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_byte     <= '0;
      out_item.valid <= 1'b0;
    end else begin
      if (advance) begin
        fault_byte     <= fault_byte_next;
        out_item.valid <= 1'b1;
      end else if (out_item.ready) begin
        out_item.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.fault_reasons  <= fault_byte_next;
      out_item.report_valid   <= report_next;
      out_item.receiver_error <= gated_in && rf_err;
    end
  end

endmodule
`default_nettype wire
